### sv/intel_hex_record_parser_macros.svh
// Assertion macros shared by the parser's checker.
// No dependencies; include this file by its bare name.
`ifndef INTEL_HEX_RECORD_PARSER_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_MACROS_SVH

// Plain property, checked at each rising clock edge outside reset.
`define HRP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Overlapping implication, checked at each rising clock edge outside reset.
`define HRP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/hrp_pkg.sv
// Shared types, codes and helper functions of the Intel HEX record parser.
// No dependencies.
`default_nettype none

package hrp_pkg;

  typedef enum logic [6:0] {
    PH_WAIT  = 7'b0000001,
    PH_COUNT = 7'b0000010,
    PH_ADDR  = 7'b0000100,
    PH_TYPE  = 7'b0001000,
    PH_DATA  = 7'b0010000,
    PH_CSUM  = 7'b0100000,
    PH_DONE  = 7'b1000000
  } phase_e;

  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_RESTART = 2'd1;
  localparam logic [1:0] KIND_EOI     = 2'd2;

  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_EOF      = 3'd2;
  localparam logic [2:0] ST_BADSTART = 3'd3;
  localparam logic [2:0] ST_CSUM     = 3'd4;
  localparam logic [2:0] ST_UNKTYPE  = 3'd5;
  localparam logic [2:0] ST_BADLEN   = 3'd6;
  localparam logic [2:0] ST_EARLY    = 3'd7;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;
  localparam logic [7:0] REC_SEG  = 8'h02;
  localparam logic [7:0] REC_LIN  = 8'h04;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] UPPER_BIAS   = 8'h37;  // 'A' - 10
  localparam logic [7:0] LOWER_BIAS   = 8'h57;  // 'a' - 10

  localparam logic [7:0] ADDR_BYTES = 8'd2;
  localparam logic [7:0] BASE_BYTES = 8'd2;

  typedef struct packed {
    phase_e      phase;
    logic        hnp;
    logic [15:0] partial;
    logic [7:0]  byte_count;
    logic [15:0] offset;
    logic [7:0]  type_byte;
    logic [7:0]  sum;
    logic [7:0]  seen;
    logic [31:0] base;
    logic [15:0] line_cnt;
    logic        halted;
  } parse_state_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [7:0]  record_type;
    logic [7:0]  given;
    logic [7:0]  computed;
    logic [15:0] line_number;
  } result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:      PH_WAIT,
    hnp:        1'b0,
    partial:    16'd0,
    byte_count: 8'd0,
    offset:     16'd0,
    type_byte:  8'd0,
    sum:        8'd0,
    seen:       8'd0,
    base:       32'd0,
    line_cnt:   16'd0,
    halted:     1'b0
  };

  // Low four bits of the digit formula; non-hex text folds in the same way.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    if (c <= CHAR_NINE) begin
      v = c - CHAR_ZERO;
    end else if (c <= CHAR_UPPER_F) begin
      v = c - UPPER_BIAS;
    end else begin
      v = c - LOWER_BIAS;
    end
    return v[3:0];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
           (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

endpackage

`default_nettype wire

### sv/hrp_step.sv
// Next-state and result logic of the parser for one accepted transaction.
// Depends on hrp_pkg.
`default_nettype none

module hrp_step (
  input  hrp_pkg::parse_state_t st_i,
  input  logic [1:0]            kind_i,
  input  logic [7:0]            character_i,
  output hrp_pkg::parse_state_t st_o,
  output logic                  res_valid_o,
  output hrp_pkg::result_t      res_o
);

  logic [15:0] pv_next;
  logic [7:0]  byte_v;
  logic [7:0]  sum_next;
  logic [7:0]  seen_inc;
  logic [7:0]  computed;

  assign pv_next  = {st_i.partial[11:0], hrp_pkg::nibble_of(character_i)};
  assign byte_v   = pv_next[7:0];
  assign sum_next = st_i.sum + byte_v;
  assign seen_inc = st_i.seen + 8'd1;
  assign computed = 8'd0 - st_i.sum;

  always_comb begin
    st_o                = st_i;
    res_valid_o         = 1'b0;
    res_o               = '0;
    res_o.record_type   = st_i.type_byte;
    res_o.line_number   = st_i.line_cnt;

    if (kind_i == hrp_pkg::KIND_RESTART) begin
      st_o = hrp_pkg::STATE_RESET;
    end else if (((kind_i == hrp_pkg::KIND_CHAR) || (kind_i == hrp_pkg::KIND_EOI)) &&
                 !st_i.halted && (st_i.phase != hrp_pkg::PH_DONE)) begin
      if (kind_i == hrp_pkg::KIND_EOI) begin
        st_o.halted  = 1'b1;
        res_valid_o  = 1'b1;
        res_o.status = hrp_pkg::ST_EARLY;
      end else if (st_i.phase == hrp_pkg::PH_WAIT) begin
        if (hrp_pkg::is_space(character_i)) begin
          st_o = st_i;
        end else if (character_i != hrp_pkg::CHAR_COLON) begin
          st_o.halted  = 1'b1;
          res_valid_o  = 1'b1;
          res_o.status = hrp_pkg::ST_BADSTART;
        end else begin
          st_o.hnp        = 1'b0;
          st_o.partial    = 16'd0;
          st_o.byte_count = 8'd0;
          st_o.offset     = 16'd0;
          st_o.type_byte  = 8'd0;
          st_o.sum        = 8'd0;
          st_o.seen       = 8'd0;
          st_o.phase      = hrp_pkg::PH_COUNT;
        end
      end else begin
        st_o.partial = pv_next;
        if (!st_i.hnp) begin
          st_o.hnp = 1'b1;
        end else begin
          st_o.hnp = 1'b0;
          unique case (st_i.phase)
            hrp_pkg::PH_COUNT: begin
              st_o.byte_count = byte_v;
              st_o.sum        = sum_next;
              st_o.seen       = 8'd0;
              st_o.phase      = hrp_pkg::PH_ADDR;
            end
            hrp_pkg::PH_ADDR: begin
              st_o.sum  = sum_next;
              st_o.seen = seen_inc;
              if (seen_inc >= hrp_pkg::ADDR_BYTES) begin
                st_o.offset = pv_next;
                st_o.phase  = hrp_pkg::PH_TYPE;
              end
            end
            hrp_pkg::PH_TYPE: begin
              st_o.type_byte    = byte_v;
              st_o.sum          = sum_next;
              st_o.seen         = 8'd0;
              st_o.partial      = 16'd0;
              res_o.record_type = byte_v;
              if (byte_v == hrp_pkg::REC_EOF) begin
                st_o.phase   = hrp_pkg::PH_DONE;
                res_valid_o  = 1'b1;
                res_o.status = hrp_pkg::ST_EOF;
              end else if (byte_v == hrp_pkg::REC_DATA) begin
                st_o.phase = (st_i.byte_count == 8'd0) ? hrp_pkg::PH_CSUM : hrp_pkg::PH_DATA;
              end else if ((byte_v == hrp_pkg::REC_SEG) || (byte_v == hrp_pkg::REC_LIN)) begin
                if (st_i.byte_count != hrp_pkg::BASE_BYTES) begin
                  st_o.halted  = 1'b1;
                  res_valid_o  = 1'b1;
                  res_o.status = hrp_pkg::ST_BADLEN;
                end else begin
                  st_o.phase = hrp_pkg::PH_DATA;
                end
              end else begin
                st_o.halted  = 1'b1;
                res_valid_o  = 1'b1;
                res_o.status = hrp_pkg::ST_UNKTYPE;
              end
            end
            hrp_pkg::PH_DATA: begin
              st_o.sum  = sum_next;
              st_o.seen = seen_inc;
              if (st_i.type_byte == hrp_pkg::REC_DATA) begin
                res_valid_o     = 1'b1;
                res_o.status    = hrp_pkg::ST_DATA;
                res_o.address   = st_i.base + {16'd0, st_i.offset} + {24'd0, st_i.seen};
                res_o.data_byte = byte_v;
              end
              if (seen_inc == st_i.byte_count) begin
                if (st_i.type_byte == hrp_pkg::REC_SEG) begin
                  st_o.base = {12'd0, pv_next, 4'd0};
                end else if (st_i.type_byte == hrp_pkg::REC_LIN) begin
                  st_o.base = {pv_next, 16'd0};
                end
                st_o.phase = hrp_pkg::PH_CSUM;
              end
            end
            hrp_pkg::PH_CSUM: begin
              res_valid_o    = 1'b1;
              res_o.given    = byte_v;
              res_o.computed = computed;
              if (byte_v != computed) begin
                st_o.halted  = 1'b1;
                res_o.status = hrp_pkg::ST_CSUM;
              end else begin
                res_o.status = hrp_pkg::ST_OK;
                if (st_i.line_cnt != 16'hFFFF) begin
                  st_o.line_cnt = st_i.line_cnt + 16'd1;
                end
                st_o.hnp        = 1'b0;
                st_o.partial    = 16'd0;
                st_o.byte_count = 8'd0;
                st_o.offset     = 16'd0;
                st_o.type_byte  = 8'd0;
                st_o.sum        = 8'd0;
                st_o.seen       = 8'd0;
                st_o.phase      = hrp_pkg::PH_WAIT;
              end
            end
            default: begin
              st_o = st_i;
            end
          endcase
        end
      end
    end
  end

endmodule

`default_nettype wire

### sv/intel_hex_record_parser.sv
// Top level of the Intel HEX record parser: parser state, result register, skid stage.
// Depends on hrp_pkg and hrp_step.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction per text
//   character, restart or end of input, selected by kind_i.
//   Output channel (out_valid_o / out_stall_i) carries at most one result per
//   input transaction: data bytes, record ok, eof or an error status.
//   Throughput: one input transaction per cycle while in_stall_o is low,
//   as the parser state is updated from each accepted transaction.
//   Output: each result is registered, into the skid stage while the output is held.
//   Reset: the parser waits for a colon with base address and record count
//   cleared; no result is pending.
//   Stall: while out_stall_i holds a result, one more result is kept in a
//   skid stage; in_stall_o rises once that stage is occupied and falls when
//   it drains.
//   After an error the parser ignores input until a restart transaction.
`default_nettype none

module intel_hex_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  character_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] address_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  record_type_o,
  output logic [7:0]  given_checksum_o,
  output logic [7:0]  computed_checksum_o,
  output logic [15:0] line_number_o
);

  hrp_pkg::parse_state_t st_q;
  hrp_pkg::parse_state_t st_d;
  hrp_pkg::result_t      res;
  hrp_pkg::result_t      out_q;
  hrp_pkg::result_t      skid_q;
  logic                  res_valid;
  logic                  out_valid_q;
  logic                  skid_valid_q;
  logic                  in_accept;
  logic                  out_free;
  logic                  res_load;

  hrp_step u_step (
    .st_i        (st_q),
    .kind_i      (kind_i),
    .character_i (character_i),
    .st_o        (st_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign res_load   = in_accept && res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= hrp_pkg::STATE_RESET;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        st_q <= st_d;
      end
      if (res_load) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_free) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_free && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_q.status;
  assign address_o           = out_q.address;
  assign data_byte_o         = out_q.data_byte;
  assign record_type_o       = out_q.record_type;
  assign given_checksum_o    = out_q.given;
  assign computed_checksum_o = out_q.computed;
  assign line_number_o       = out_q.line_number;

endmodule

`default_nettype wire

### sv/hrp_checker.sv
// Port-level checker for the Intel HEX record parser, bound to the top level.
// Depends on hrp_pkg and intel_hex_record_parser_macros.svh.
`default_nettype none
`include "intel_hex_record_parser_macros.svh"

module hrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  kind_i,
  input logic [7:0]  character_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [31:0] address_o,
  input logic [7:0]  data_byte_o,
  input logic [7:0]  record_type_o,
  input logic [7:0]  given_checksum_o,
  input logic [7:0]  computed_checksum_o,
  input logic [15:0] line_number_o
);

  logic in_accept;
  logic [9:0] in_bits;
  logic [82:0] out_bits;
  logic out_held;
  logic is_data;
  logic is_ctrl;
  logic is_sum;
  logic restart_idle;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_bits   = {kind_i, character_i};
  assign out_bits  = {status_o, address_o, data_byte_o, record_type_o, given_checksum_o,
                      computed_checksum_o, line_number_o};
  assign out_held  = out_valid_o && out_stall_i;
  assign is_data   = out_valid_o && (status_o == hrp_pkg::ST_DATA);
  assign is_ctrl   = out_valid_o && (status_o != hrp_pkg::ST_DATA);
  assign is_sum    = out_valid_o &&
                     ((status_o == hrp_pkg::ST_OK) || (status_o == hrp_pkg::ST_CSUM));
  assign restart_idle = in_accept && (in_bits[9:8] == hrp_pkg::KIND_RESTART) && !out_valid_o;

  `HRP_ASSERT(a_out_hold, clk_i, rst_ni,
    out_held |=> out_valid_o && $stable(out_bits), "stalled transaction changed")
  `HRP_ASSERT_IMPL(a_data_fields, clk_i, rst_ni, is_data,
    (record_type_o == hrp_pkg::REC_DATA) && (given_checksum_o == 8'd0) &&
    (computed_checksum_o == 8'd0), "data transaction with stray fields")
  `HRP_ASSERT_IMPL(a_ctrl_fields, clk_i, rst_ni, is_ctrl,
    (address_o == 32'd0) && (data_byte_o == 8'd0), "status transaction with address or data")
  `HRP_ASSERT_IMPL(a_csum_match, clk_i, rst_ni, is_sum,
    (status_o == hrp_pkg::ST_OK) == (given_checksum_o == computed_checksum_o),
    "checksum status disagrees with checksum fields")
  `HRP_ASSERT(a_restart_quiet, clk_i, rst_ni,
    restart_idle |=> !out_valid_o, "restart produced a result")

endmodule

bind intel_hex_record_parser hrp_checker u_hrp_checker (.*);

`default_nettype wire
